### rtl/core/spl_pkg.sv
package spl_pkg;

    // Fixed field widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 5;
    localparam int unsigned LINE_W   = 24;
    localparam int unsigned COL_W    = 16;
    localparam int unsigned DATA_W   = 64;
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned PAT_W    = 2 * DATA_W;

    // Special text bytes
    localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [BYTE_W-1:0] NUL_CHAR     = 8'h00;

    // Counter saturation limits
    localparam logic [LINE_W-1:0] LINE_LIMIT = '1;
    localparam logic [COL_W-1:0]  COL_LIMIT  = '1;

    // Register index, taken from paddr[4:3]
    typedef enum logic [1:0] {
        REG_LENGTH    = 2'd0,
        REG_PAT_LOW   = 2'd1,
        REG_PAT_HIGH  = 2'd2,
        REG_UNUSED    = 2'd3
    } reg_idx_t;

    // Pattern setup handed from the register file to the matcher
    typedef struct packed {
        logic [LEN_W-1:0] length;   // already clamped to 1..PATTERN_MAX
        logic [PAT_W-1:0] bytes;    // byte i in bits 8i+7:8i
    } pat_cfg_t;

endpackage

### rtl/core/stream_pattern_locator_unit.sv
// A request accepted into the input stage register loads the result register on
// a match as the stage drains; a result held under out_stall stalls the stage.
// Throughput: one text byte per cycle while no result is held by out_stall;
// the line, column and partial-match update is combinational into its registers.
// Reset (rst_n low, asynchronous): pattern length 1, pattern bytes zero,
// line and column 1, partial matches cleared, both stages empty.
module stream_pattern_locator_unit
    import spl_pkg::*;
#(
    parameter int unsigned PATTERN_MAX = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [BYTE_W-1:0]   text_byte,
    input  logic                first_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [LINE_W-1:0]   match_line,
    output logic [COL_W-1:0]    match_column
);

    pat_cfg_t cfg;

    // Pattern registers
    spl_regs #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Scanner
    spl_match #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_match (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .text_byte    (text_byte),
        .first_byte   (first_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .match_line   (match_line),
        .match_column (match_column)
    );

endmodule

### rtl/core/spl_regs.sv
module spl_regs
    import spl_pkg::*;
#(
    parameter int unsigned PATTERN_MAX = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    output pat_cfg_t            cfg
);

    logic [LEN_W-1:0]  length_reg;
    logic [DATA_W-1:0] pat_low_reg;
    logic [DATA_W-1:0] pat_high_reg;
    logic              wr_en;
    reg_idx_t          idx;
    logic [LEN_W-1:0]  eff_len;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg   <= LEN_W'(1);
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_LENGTH:   length_reg   <= pwdata[LEN_W-1:0];
                REG_PAT_LOW:  pat_low_reg  <= pwdata;
                REG_PAT_HIGH: pat_high_reg <= pwdata;
                default:      ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            REG_LENGTH:   prdata = {{(DATA_W-LEN_W){1'b0}}, length_reg};
            REG_PAT_LOW:  prdata = pat_low_reg;
            REG_PAT_HIGH: prdata = pat_high_reg;
            default:      prdata = '0;
        endcase
    end

    // Length clamp: zero acts as one, above the maximum acts as the maximum
    always_comb
    begin
        if (length_reg == '0)
            eff_len = LEN_W'(1);
        else if (length_reg > LEN_W'(PATTERN_MAX))
            eff_len = LEN_W'(PATTERN_MAX);
        else
            eff_len = length_reg;
    end

    assign cfg.length = eff_len;
    assign cfg.bytes  = {pat_high_reg, pat_low_reg};

endmodule

### rtl/core/spl_match.sv
module spl_match
    import spl_pkg::*;
#(
    parameter int unsigned PATTERN_MAX = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  pat_cfg_t            cfg,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [BYTE_W-1:0]   text_byte,
    input  logic                first_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [LINE_W-1:0]   match_line,
    output logic [COL_W-1:0]    match_column
);

    // Input stage
    logic                   s1_valid_reg, s1_valid_next;
    logic [BYTE_W-1:0]      s1_byte_reg;
    logic                   s1_first_reg;
    logic                   s1_fire;
    logic                   accept;

    // Scan state
    logic [LINE_W-1:0]      line_reg, line_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [PATTERN_MAX-1:0] pm_reg, pm_next;

    // Result register
    logic                   out_valid_reg, out_valid_next;
    logic [LINE_W-1:0]      out_line_reg;
    logic [COL_W-1:0]       out_col_reg;

    // Update logic
    logic [LINE_W-1:0]      line_a;
    logic [COL_W-1:0]       col_a;
    logic [PATTERN_MAX-1:0] pm_a, pm_n, char_mask, len_mask;
    logic                   hit;
    logic [COL_W-1:0]       len_ext, start_col;

    // Handshake: the input stage drains unless a result is held under out_stall
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg  <= text_byte;
            s1_first_reg <= first_byte;
        end
    end

    // Per-pattern-byte compare mask, limited to the active length
    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            len_mask[i]  = (LEN_W'(i) < cfg.length);
            char_mask[i] = len_mask[i] && (cfg.bytes[8*i +: 8] == s1_byte_reg);
        end
    end

    // Position counters and shift-and update
    always_comb
    begin
        line_a = s1_first_reg ? LINE_W'(1) : line_reg;
        col_a  = s1_first_reg ? COL_W'(1)  : col_reg;
        pm_a   = s1_first_reg ? '0         : pm_reg;

        line_next = line_a;
        col_next  = col_a;
        if (s1_byte_reg != NUL_CHAR && col_a != COL_LIMIT)
            col_next = col_a + COL_W'(1);
        if (s1_byte_reg == NEWLINE_CHAR)
        begin
            if (line_a != LINE_LIMIT)
                line_next = line_a + LINE_W'(1);
            col_next = COL_W'(1);
        end

        pm_n = PATTERN_MAX'({pm_a, 1'b1}) & char_mask;

        // Match when the bit for the last active pattern byte is set
        hit = 1'b0;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (pm_n[i] && (LEN_W'(i + 1) == cfg.length))
                hit = 1'b1;
        end

        pm_next = hit ? '0 : pm_n;

        len_ext   = {{(COL_W-LEN_W){1'b0}}, cfg.length};
        start_col = (col_next >= len_ext) ? (col_next - len_ext) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg <= LINE_W'(1);
            col_reg  <= COL_W'(1);
            pm_reg   <= '0;
        end
        else if (s1_fire)
        begin
            line_reg <= line_next;
            col_reg  <= col_next;
            pm_reg   <= pm_next;
        end
    end

    // Result register
    always_comb
    begin
        if (s1_fire && hit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && hit)
        begin
            out_line_reg <= line_next;
            out_col_reg  <= start_col;
        end
    end

    assign out_valid    = out_valid_reg;
    assign match_line   = out_line_reg;
    assign match_column = out_col_reg;

`ifndef NO_ASSERTIONS
    // A match always leaves the partial-match vector empty
    a_clear_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && hit |=> pm_reg == '0)
        else $error("partial matches not cleared after a match");

    // No updated partial match beyond the active pattern length
    a_pm_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |-> (pm_n & ~len_mask) == '0)
        else $error("partial match bit beyond pattern length");

    // Line and column counters never reach zero
    a_counts_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != '0 && col_reg != '0)
        else $error("position counter reached zero");

    // A held result is never overwritten by the input stage
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !s1_fire)
        else $error("input stage advanced over a held result");
`endif

endmodule

### verif/stream_pattern_locator_unit_tb.sv
module stream_pattern_locator_unit_tb;
    import spl_pkg::*;

    localparam int unsigned PATTERN_MAX  = 16;
    localparam int unsigned SETTLE_WAIT  = 6;     // drain margin after the last result
    localparam int unsigned HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int unsigned QUIET_LIMIT  = 3000;  // cycles with no request or result moving

    typedef struct packed {
        logic [BYTE_W-1:0] text;
        logic              first;
    } text_req_t;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  col;
    } match_rec_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [ADDR_W-1:0]   paddr       = '0;
    logic [DATA_W-1:0]   pwdata      = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic [BYTE_W-1:0]   text_byte   = '0;
    logic                first_byte  = 1'b0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    logic [LINE_W-1:0]   match_line;
    logic [COL_W-1:0]    match_column;

    // Requests waiting to be sent, and matches still owed by the block
    text_req_t   pending_q[$];
    match_rec_t  match_q[$];

    // Scan state mirrored from the block
    logic [LEN_W-1:0]   scan_len     = 5'd1;
    logic [PAT_W-1:0]   scan_pat     = '0;
    logic [LINE_W-1:0]  scan_line    = 24'd1;
    logic [COL_W-1:0]   scan_col     = 16'd1;
    logic [15:0]        scan_partial = '0;

    int unsigned  err_count    = 0;
    int unsigned  tx_gap       = 0;
    int unsigned  rx_left      = 0;
    int unsigned  rx_gap       = 0;
    int unsigned  quiet_cycles = 0;
    bit           steady       = 1'b0;
    bit           hold_tog     = 1'b0;
    bit           hold_seen    = 1'b0;
    text_req_t    drv_req;
    match_rec_t   mon_want;

    stream_pattern_locator_unit #(.PATTERN_MAX(PATTERN_MAX)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .text_byte    (text_byte),
        .first_byte   (first_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .match_line   (match_line),
        .match_column (match_column)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly no gap, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Shift-and update of the mirrored scan state for one accepted request
    function automatic void predict_match(input logic [BYTE_W-1:0] c, input logic first);
        int unsigned  eff;
        int unsigned  i;
        logic [15:0]  mask;
        match_rec_t   rec;
        eff = (scan_len == 0) ? 1 : (scan_len > PATTERN_MAX) ? PATTERN_MAX : scan_len;
        mask = '0;
        for (i = 0; i < eff; i++)
            if (scan_pat[8*i +: 8] == c)
                mask[i] = 1'b1;
        if (first)
        begin
            scan_line    = 24'd1;
            scan_col     = 16'd1;
            scan_partial = '0;
        end
        if (c != NUL_CHAR && scan_col != COL_LIMIT)
            scan_col = scan_col + 16'd1;
        if (c == NEWLINE_CHAR)
        begin
            if (scan_line != LINE_LIMIT)
                scan_line = scan_line + 24'd1;
            scan_col = 16'd1;
        end
        scan_partial = ((scan_partial << 1) | 16'd1) & mask;
        if (scan_partial[eff-1])
        begin
            scan_partial = '0;
            rec.line = scan_line;
            rec.col  = (scan_col >= eff) ? COL_W'(scan_col - eff) : '0;
            match_q.push_back(rec);
        end
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (err_count < 40)
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        err_count++;
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            text_byte  <= '0;
            first_byte <= 1'b0;
            tx_gap     <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (tx_gap > 0)
            begin
                tx_gap   <= tx_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                drv_req = pending_q.pop_front();
                in_valid   <= 1'b1;
                text_byte  <= drv_req.text;
                first_byte <= drv_req.first;
                tx_gap     <= steady ? 0 : pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result receiver: random stalls plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_left   <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_tog != hold_seen)
        begin
            hold_seen <= hold_tog;
            rx_left   <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (rx_left > 0)
        begin
            rx_left   <= rx_left - 1;
            out_stall <= 1'b1;
        end
        else if (steady)
            out_stall <= 1'b0;
        else
        begin
            rx_gap = pick_gap();
            out_stall <= (rx_gap != 0);
            rx_left   <= (rx_gap == 0) ? 0 : rx_gap - 1;
        end
    end

    // Monitor: check results first, then predict from the accepted request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (match_q.size() == 0)
                    report_mismatch("unexpected result, line", match_line, 0);
                else
                begin
                    mon_want = match_q.pop_front();
                    if (match_line !== mon_want.line)
                        report_mismatch("match_line", match_line, mon_want.line);
                    if (match_column !== mon_want.col)
                        report_mismatch("match_column", match_column, mon_want.col);
                end
            end
            if (in_valid && !in_stall)
                predict_match(text_byte, first_byte);
        end
    end

    // Watchdog on traffic
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles < QUIET_LIMIT)
            quiet_cycles <= quiet_cycles + 1;
        else
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic reg_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LENGTH:   scan_len = value[LEN_W-1:0];
            REG_PAT_LOW:  scan_pat[DATA_W-1:0] = value;
            REG_PAT_HIGH: scan_pat[PAT_W-1:DATA_W] = value;
            default:      ;
        endcase
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] c, input logic first);
        text_req_t req;
        req.text  = c;
        req.first = first;
        pending_q.push_back(req);
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_byte(s[i], 1'b0);
    endtask

    // Wait until every request is sent and every match returned, then drain
    task automatic settle();
        @(negedge clk);
        while (pending_q.size() != 0 || in_valid || match_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_WAIT) @(negedge clk);
    endtask

    // New pattern, mostly over a small alphabet, then text built mostly from it
    task automatic random_phase(input logic [LEN_W-1:0] len_reg, input int unsigned n_items);
        logic [BYTE_W-1:0]  alpha [0:2];
        logic [PAT_W-1:0]   pat;
        int unsigned        eff, k, r, i, cut;
        for (i = 0; i < 3; i++)
        begin
            r = $urandom_range(0, 9);
            alpha[i] = (r == 0) ? NEWLINE_CHAR : (r == 1) ? NUL_CHAR : BYTE_W'($urandom);
        end
        for (i = 0; i < 16; i++)
            pat[8*i +: 8] = alpha[$urandom_range(0, 2)];
        if ($urandom_range(0, 5) == 0)
            pat = {$urandom, $urandom, $urandom, $urandom};
        reg_write(REG_LENGTH, DATA_W'(len_reg));
        reg_write(REG_PAT_LOW, pat[DATA_W-1:0]);
        reg_write(REG_PAT_HIGH, pat[PAT_W-1:DATA_W]);
        eff = (len_reg == 0) ? 1 : (len_reg > PATTERN_MAX) ? PATTERN_MAX : len_reg;
        k = 0;
        while (k < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                push_byte(alpha[$urandom_range(0, 2)], 1'b0);
                k++;
            end
            else if (r < 55)
            begin
                for (i = 0; i < eff; i++)
                    push_byte(pat[8*i +: 8], 1'b0);
                k += eff;
            end
            else if (r < 59)
            begin
                // broken occurrence: a prefix only
                cut = $urandom_range(0, eff - 1);
                for (i = 0; i < cut; i++)
                    push_byte(pat[8*i +: 8], 1'b0);
                k += cut;
            end
            else if (r < 65)
            begin
                push_byte(NEWLINE_CHAR, 1'b0);
                k++;
            end
            else if (r < 69)
            begin
                push_byte(NUL_CHAR, 1'b0);
                k++;
            end
            else if (r < 73)
            begin
                push_byte(BYTE_W'($urandom), 1'b1);
                k++;
            end
            else
            begin
                push_byte(BYTE_W'($urandom), 1'b0);
                k++;
            end
        end
    endtask

    logic [LEN_W-1:0] phase_len [0:8] = '{5'd0, 5'd2, 5'd5, 5'd16, 5'd1, 5'd17,
                                         5'd8, 5'd31, 5'd3};

    initial
    begin
        int p, i;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset setup: single NUL pattern, start column below one on a match
        @(negedge clk);
        push_byte(NUL_CHAR, 1'b1);
        push_byte("a", 1'b0);
        push_byte(NEWLINE_CHAR, 1'b0);
        push_byte(NUL_CHAR, 1'b0);
        push_byte(8'hFF, 1'b0);
        settle();

        // Three-byte pattern, restart after a mismatch; unused index is ignored
        reg_write(REG_LENGTH, 64'd3);
        reg_write(REG_PAT_LOW, 64'h636261);
        reg_write(REG_UNUSED, '1);
        @(negedge clk);
        push_text("aabc");
        settle();

        // Length above the maximum, all-ones pattern
        reg_write(REG_LENGTH, 64'd31);
        reg_write(REG_PAT_LOW, '1);
        reg_write(REG_PAT_HIGH, '1);
        @(negedge clk);
        for (i = 0; i < 16; i++)
            push_byte(8'hFF, 1'b0);
        settle();

        // Random phases over several lengths
        for (p = 0; p < 9; p++)
        begin
            steady = (p == 5);
            random_phase(phase_len[p], 72);
            @(negedge clk);
            if (p == 3)
                hold_tog = ~hold_tog;
            settle();
            steady = 1'b0;
        end

        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
